// ===== src/esic_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, register indexes and reset values for the encoder speed controller.
package esic_pkg;

    localparam int COUNT_W  = 32;
    localparam int TARGET_W = 16;
    localparam int GAIN_W   = 24;
    localparam int LIMIT_W  = 16;
    localparam int DRIVE_W  = 16;
    localparam int SPEED_W  = 31;
    localparam int ERR_W    = 32;
    localparam int FRAC_W   = 16;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_LIMIT = 1'd1;

    localparam logic [GAIN_W-1:0]  KP_GAIN_RST   = 24'd655;
    localparam logic [LIMIT_W-1:0] PWM_LIMIT_RST = 16'd15000;

    typedef logic [COUNT_W-1:0] count_t;

endpackage

// ===== src/encoder_speed_integral_controller_unit.sv =====
`timescale 1ns / 1ps
// Encoder speed controller: measured speed, error and incremental P drive update.
//
// Input channel (in_valid / in_stall) takes one word per sampling tick: the
// extended encoder position and the target speed. Output channel (out_valid /
// out_stall) returns one word per tick: kept drive value, update flag,
// measured speed and signed speed error.
// An accepted word runs through a small sequencer: speed scaling and error,
// two passes through one shared 24x16 multiplier (gain times low and high
// half of the error magnitude), then the Q16 add, truncation and clamp.
// in_stall is high from acceptance until the finished word is written to the
// output register, so the next word is taken only after the previous one is done.
// A finished word waits in the output register while out_stall is high; the
// next input word can be accepted meanwhile, but its final step holds until
// the output register is taken.
// Reset clears the previous position and the kept drive value to zero and
// loads kp_gain = 655, pwm_limit = 15000. Configuration (cfg_we, cfg_index,
// cfg_data) is to be written only while the block is idle; the block does not enforce it.
module encoder_speed_integral_controller_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [esic_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [esic_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [esic_pkg::COUNT_W-1:0]  encoder_count,
    input  logic [esic_pkg::TARGET_W-1:0] target_speed,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [esic_pkg::DRIVE_W-1:0]  drive_value,
    output logic                          drive_update,
    output logic [esic_pkg::SPEED_W-1:0]  measured_speed,
    output logic signed [esic_pkg::ERR_W-1:0] speed_error
);
    import esic_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SPEED = 3'd1;
    localparam logic [2:0] ST_MLO   = 3'd2;
    localparam logic [2:0] ST_MHI   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam int PROD_W = GAIN_W + 16;
    localparam int MAG_W  = GAIN_W + SPEED_W;
    localparam int SUM_W  = MAG_W + 1;

    logic [2:0]          state_reg, state_next;
    logic [GAIN_W-1:0]   kp_gain_reg;
    logic [LIMIT_W-1:0]  pwm_limit_reg;
    count_t              last_count_reg;
    logic [DRIVE_W-1:0]  acc_reg;
    count_t              delta_reg;
    logic [TARGET_W-1:0] target_reg;
    logic [SPEED_W-1:0]  speed_reg;
    logic [ERR_W-1:0]    err_reg;
    logic [SPEED_W-1:0]  emag_reg;
    logic                err_neg_reg;
    logic [MAG_W-1:0]    mag_reg;
    logic                out_valid_reg;
    logic [DRIVE_W-1:0]  drive_value_reg;
    logic                drive_update_reg;
    logic [SPEED_W-1:0]  speed_out_reg;
    logic [ERR_W-1:0]    err_out_reg;

    logic                in_take;
    logic                out_free;
    logic                finish;
    count_t              delta_next;
    logic [COUNT_W+4:0]  speed_full;
    logic [SPEED_W-1:0]  speed_sat;
    logic [ERR_W-1:0]    err_calc;
    logic [15:0]         mul_b;
    logic [PROD_W-1:0]   prod;
    logic [SUM_W-1:0]    base_ext;
    logic [SUM_W-1:0]    mag_ext;
    logic [SUM_W-1:0]    sum_val;
    logic [SUM_W-FRAC_W-1:0] q_val;
    logic                q_ge;
    logic [DRIVE_W-1:0]  drive_calc;
    logic                upd_calc;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign finish   = (state_reg == ST_DONE) && out_free;

    assign delta_next = (encoder_count >= last_count_reg) ?
                        (encoder_count - last_count_reg) : (last_count_reg - encoder_count);

    // delta * 30 = delta * 32 - delta * 2
    assign speed_full = {delta_reg, 5'b0} - {4'b0, delta_reg, 1'b0};
    assign speed_sat  = (speed_full[COUNT_W+4:SPEED_W] != '0) ? {SPEED_W{1'b1}}
                                                             : speed_full[SPEED_W-1:0];
    assign err_calc   = {{(ERR_W-TARGET_W){1'b0}}, target_reg} - {1'b0, speed_sat};

    // shared multiplier: gain times one half of the error magnitude
    assign mul_b = (state_reg == ST_MHI) ? {1'b0, emag_reg[SPEED_W-1:16]} : emag_reg[15:0];
    assign prod  = kp_gain_reg * mul_b;

    always_comb
    begin
        base_ext = {{(SUM_W-DRIVE_W-FRAC_W){1'b0}}, acc_reg, {FRAC_W{1'b0}}};
        mag_ext  = {1'b0, mag_reg};
        sum_val  = '0;
        if (!err_neg_reg)
        begin
            sum_val = base_ext + mag_ext;
        end
        else if (mag_ext <= base_ext)
        begin
            sum_val = base_ext - mag_ext;
        end
        // negative result truncates toward zero and clamps to 0
        q_val = sum_val[SUM_W-1:FRAC_W];
        q_ge  = (q_val >= {{(SUM_W-FRAC_W-LIMIT_W){1'b0}}, pwm_limit_reg});
        upd_calc = (q_val != '0) && !q_ge;
        if (!q_ge)
        begin
            drive_calc = q_val[DRIVE_W-1:0];
        end
        else if (pwm_limit_reg == '0)
        begin
            drive_calc = '0;
        end
        else
        begin
            drive_calc = pwm_limit_reg - 16'd1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_SPEED;
                end
            end
            ST_SPEED: state_next = ST_MLO;
            ST_MLO:   state_next = ST_MHI;
            ST_MHI:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            kp_gain_reg    <= KP_GAIN_RST;
            pwm_limit_reg  <= PWM_LIMIT_RST;
            last_count_reg <= '0;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_KP_GAIN:   kp_gain_reg   <= cfg_data[GAIN_W-1:0];
                    REG_PWM_LIMIT: pwm_limit_reg <= cfg_data[LIMIT_W-1:0];
                    default:       ;
                endcase
            end
            if (in_take)
            begin
                last_count_reg <= encoder_count;
            end
            if (finish)
            begin
                acc_reg       <= drive_calc;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            delta_reg  <= delta_next;
            target_reg <= target_speed;
        end
        case (state_reg)
            ST_SPEED:
            begin
                speed_reg   <= speed_sat;
                err_reg     <= err_calc;
                err_neg_reg <= err_calc[ERR_W-1];
                emag_reg    <= err_calc[ERR_W-1] ? (~err_calc[SPEED_W-1:0] + 31'd1)
                                                 : err_calc[SPEED_W-1:0];
            end
            ST_MLO:
            begin
                mag_reg <= {{(MAG_W-PROD_W){1'b0}}, prod};
            end
            ST_MHI:
            begin
                mag_reg <= mag_reg + {prod[MAG_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
            end
            default: ;
        endcase
        if (finish)
        begin
            drive_value_reg  <= drive_calc;
            drive_update_reg <= upd_calc;
            speed_out_reg    <= speed_reg;
            err_out_reg      <= err_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign drive_value    = drive_value_reg;
    assign drive_update   = drive_update_reg;
    assign measured_speed = speed_out_reg;
    assign speed_error    = err_out_reg;

    a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == ST_SPEED))
        else $error("accepted word did not start the sequencer");

    a_update_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && drive_update_reg) |-> (drive_value_reg != '0))
        else $error("update flag with zero drive");

    a_drive_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (pwm_limit_reg != '0)) |-> (drive_value_reg < pwm_limit_reg))
        else $error("drive value above limit");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && out_stall) |=> (state_reg == ST_DONE))
        else $error("result step did not wait for output register");

endmodule
